// File: rtl/binary_trie_max_xor_macros.svh
// assertion helpers shared by the rtl
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// holds at every clock edge out of reset
`define BTMX_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BTMX_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTMX_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/btmx_pkg.sv
`timescale 1ns / 1ps
package btmx_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam int STEP_W = 4;
    localparam int ACT_W  = 4;
    localparam int COND_W = 4;

    // program steps
    localparam logic [STEP_W-1:0] S_RST      = 4'd0;
    localparam logic [STEP_W-1:0] S_FIN      = 4'd1;
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd2;
    localparam logic [STEP_W-1:0] S_DISP_INS = 4'd3;
    localparam logic [STEP_W-1:0] S_DISP_QRY = 4'd4;
    localparam logic [STEP_W-1:0] S_DISP_CLR = 4'd5;
    localparam logic [STEP_W-1:0] S_NOP      = 4'd6;
    localparam logic [STEP_W-1:0] S_INS_CHK  = 4'd7;
    localparam logic [STEP_W-1:0] S_INS_WALK = 4'd8;
    localparam logic [STEP_W-1:0] S_INS_LEAF = 4'd9;
    localparam logic [STEP_W-1:0] S_QRY_CHK  = 4'd10;
    localparam logic [STEP_W-1:0] S_QRY_WALK = 4'd11;
    localparam logic [STEP_W-1:0] S_QRY_END  = 4'd12;
    localparam logic [STEP_W-1:0] S_CLR      = 4'd13;

    // datapath actions
    localparam logic [ACT_W-1:0] A_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] A_ROOT     = 4'd1;
    localparam logic [ACT_W-1:0] A_EMIT     = 4'd2;
    localparam logic [ACT_W-1:0] A_LOAD     = 4'd3;
    localparam logic [ACT_W-1:0] A_POOL     = 4'd4;
    localparam logic [ACT_W-1:0] A_INS_STEP = 4'd5;
    localparam logic [ACT_W-1:0] A_INS_END  = 4'd6;
    localparam logic [ACT_W-1:0] A_QCHK     = 4'd7;
    localparam logic [ACT_W-1:0] A_QRY_STEP = 4'd8;
    localparam logic [ACT_W-1:0] A_QRY_END  = 4'd9;
    localparam logic [ACT_W-1:0] A_CLEAR    = 4'd10;

    // jump conditions
    localparam logic [COND_W-1:0] C_ALWAYS   = 4'd0;
    localparam logic [COND_W-1:0] C_NO_ITEM  = 4'd1;
    localparam logic [COND_W-1:0] C_CMD_INS  = 4'd2;
    localparam logic [COND_W-1:0] C_CMD_QRY  = 4'd3;
    localparam logic [COND_W-1:0] C_CMD_CLR  = 4'd4;
    localparam logic [COND_W-1:0] C_POOL_LOW = 4'd5;
    localparam logic [COND_W-1:0] C_MORE     = 4'd6;
    localparam logic [COND_W-1:0] C_EMPTY    = 4'd7;
    localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_item;
        logic cmd_ins;
        logic cmd_qry;
        logic cmd_clr;
        logic pool_low;
        logic more;
        logic empty;
        logic out_busy;
    } t_flags;

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword uc_fetch(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_RST:      w = '{A_ROOT,     C_ALWAYS,   S_IDLE};
            S_FIN:      w = '{A_EMIT,     C_OUT_BUSY, S_FIN};
            S_IDLE:     w = '{A_LOAD,     C_NO_ITEM,  S_IDLE};
            S_DISP_INS: w = '{A_NONE,     C_CMD_INS,  S_INS_CHK};
            S_DISP_QRY: w = '{A_NONE,     C_CMD_QRY,  S_QRY_CHK};
            S_DISP_CLR: w = '{A_NONE,     C_CMD_CLR,  S_CLR};
            S_NOP:      w = '{A_NONE,     C_ALWAYS,   S_FIN};
            S_INS_CHK:  w = '{A_POOL,     C_POOL_LOW, S_FIN};
            S_INS_WALK: w = '{A_INS_STEP, C_MORE,     S_INS_WALK};
            S_INS_LEAF: w = '{A_INS_END,  C_ALWAYS,   S_FIN};
            S_QRY_CHK:  w = '{A_QCHK,     C_EMPTY,    S_FIN};
            S_QRY_WALK: w = '{A_QRY_STEP, C_MORE,     S_QRY_WALK};
            S_QRY_END:  w = '{A_QRY_END,  C_ALWAYS,   S_FIN};
            S_CLR:      w = '{A_CLEAR,    C_ALWAYS,   S_FIN};
            default:    w = '{A_NONE,     C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/btmx_if.sv
`timescale 1ns / 1ps
interface btmx_req_if;
    import btmx_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface btmx_rsp_if;
    import btmx_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] best_xor;
    logic [VALUE_W-1:0] running_best;
    logic               set_empty;
    logic               pool_full;

    modport source (output valid, best_xor, running_best, set_empty, pool_full, input ready);
    modport sink   (input valid, best_xor, running_best, set_empty, pool_full, output ready);
endinterface

// File: rtl/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// channel   dir  modport  beat carries
// i_req     in   sink     command, value
// o_rsp     out  source   best_xor, running_best, set_empty, pool_full
//
// insert: load, dispatch, pool check, one walk step per level, leaf step, emit
// query: load, dispatch, empty check, walks, end, emit; others: clear or no-op, emit
// the walk reads one trie level per cycle from the one-read one-write node memory
// reset writes the root entry before the first item is taken
// node memory is not cleared apart from the root entry; unwritten entries are never followed
// a held result stalls the sequencer in its emit step; one item in flight
module binary_trie_max_xor #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btmx_req_if.sink   i_req,
    btmx_rsp_if.source o_rsp
);
    import btmx_pkg::*;
    `include "binary_trie_max_xor_macros.svh"

    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = NW + 1;
    localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam logic [CW-1:0] POOL_LIMIT = CW'(NODE_COUNT - KEY_BITS);
    localparam logic [LW-1:0] TOP_LEVEL  = LW'(KEY_BITS - 1);

    t_uword w_ctl;
    t_flags w_flags;

    logic [2*NW-1:0]     r_mem [NODE_COUNT];
    logic [2*NW-1:0]     r_rdata;
    logic                w_we;
    logic [NW-1:0]       w_waddr;
    logic [2*NW-1:0]     w_wdata;
    logic [NW-1:0]       w_raddr;

    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_acc;
    logic [LW-1:0]       r_level;
    logic [NW-1:0]       r_node;
    logic                r_fresh;
    logic                r_dead;
    logic [CW-1:0]       r_nodes_used;
    logic                r_nonempty;
    logic [VALUE_W-1:0]  r_best;
    logic                r_flag_empty;
    logic                r_flag_full;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_best;
    logic [VALUE_W-1:0]  r_out_run;
    logic                r_out_empty;
    logic                r_out_full;

    logic [KEY_BITS-1:0] w_key;
    logic [VALUE_W-1:0]  w_acc32;
    logic                w_bit;
    logic [NW-1:0]       w_lnk0;
    logic [NW-1:0]       w_lnk1;
    logic [NW-1:0]       w_link;
    logic [NW-1:0]       w_other;
    logic [NW-1:0]       w_new;
    logic                w_hit;
    logic [NW-1:0]       w_ins_next;
    logic [NW-1:0]       w_opp;
    logic [NW-1:0]       w_same;
    logic                w_take_opp;
    logic                w_take_same;
    logic [NW-1:0]       w_qry_next;
    logic                w_pool_low;
    logic                w_out_busy;
    logic                w_accept;

    btmx_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    generate
        if (KEY_BITS > VALUE_W) begin : g_key_wide
            assign w_key   = {{(KEY_BITS-VALUE_W){1'b0}}, i_req.value};
            assign w_acc32 = r_acc[VALUE_W-1:0];
        end else if (KEY_BITS == VALUE_W) begin : g_key_same
            assign w_key   = i_req.value;
            assign w_acc32 = r_acc;
        end else begin : g_key_narrow
            assign w_key   = i_req.value[KEY_BITS-1:0];
            assign w_acc32 = {{(VALUE_W-KEY_BITS){1'b0}}, r_acc};
        end
    endgenerate

    assign w_bit  = r_key[r_level];
    assign w_lnk0 = r_rdata[NW-1:0];
    assign w_lnk1 = r_rdata[2*NW-1:NW];

    // insert walk: fresh nodes have no children yet
    assign w_link     = w_bit ? w_lnk1 : w_lnk0;
    assign w_other    = r_fresh ? '0 : (w_bit ? w_lnk0 : w_lnk1);
    assign w_new      = r_nodes_used[NW-1:0];
    assign w_hit      = !r_fresh && (w_link != '0);
    assign w_ins_next = w_hit ? w_link : w_new;

    // query walk: prefer the opposite bit
    assign w_opp       = w_bit ? w_lnk0 : w_lnk1;
    assign w_same      = w_bit ? w_lnk1 : w_lnk0;
    assign w_take_opp  = !r_dead && (w_opp != '0);
    assign w_take_same = !r_dead && !w_take_opp && (w_same != '0);
    assign w_qry_next  = w_take_opp ? w_opp : w_same;

    assign w_pool_low = r_nodes_used > POOL_LIMIT;
    assign w_out_busy = r_out_valid && !o_rsp.ready;
    assign w_accept   = i_req.valid && i_req.ready;

    assign w_flags.no_item  = !i_req.valid;
    assign w_flags.cmd_ins  = r_cmd == CMD_INSERT;
    assign w_flags.cmd_qry  = r_cmd == CMD_QUERY;
    assign w_flags.cmd_clr  = r_cmd == CMD_CLEAR;
    assign w_flags.pool_low = w_pool_low;
    assign w_flags.more     = r_level != '0;
    assign w_flags.empty    = !r_nonempty;
    assign w_flags.out_busy = w_out_busy;

    assign i_req.ready = w_ctl.act == A_LOAD;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = '0;
        unique case (w_ctl.act)
            A_ROOT, A_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = '0;
            end
            A_INS_STEP: begin
                w_we    = !w_hit;
                w_wdata = w_bit ? {w_new, w_other} : {w_other, w_new};
            end
            A_INS_END: begin
                w_we = r_fresh;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (w_ctl.act)
            A_INS_STEP: w_raddr = w_ins_next;
            A_QRY_STEP: w_raddr = w_qry_next;
            default:    w_raddr = '0;
        endcase
    end

    // node memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        unique case (w_ctl.act)
            A_LOAD: begin
                if (i_req.valid) begin
                    r_cmd        <= i_req.command;
                    r_key        <= w_key;
                    r_acc        <= '0;
                    r_level      <= TOP_LEVEL;
                    r_node       <= '0;
                    r_fresh      <= 1'b0;
                    r_dead       <= 1'b0;
                    r_flag_empty <= 1'b0;
                    r_flag_full  <= 1'b0;
                end
            end
            A_POOL: begin
                r_flag_full <= w_pool_low;
            end
            A_QCHK: begin
                r_flag_empty <= !r_nonempty;
            end
            A_INS_STEP: begin
                r_node  <= w_ins_next;
                r_level <= r_level - LW'(1);
                if (!w_hit) begin
                    r_fresh <= 1'b1;
                end
            end
            A_QRY_STEP: begin
                r_level <= r_level - LW'(1);
                if (w_take_opp) begin
                    r_acc[r_level] <= 1'b1;
                end
                if (w_take_opp || w_take_same) begin
                    r_node <= w_qry_next;
                end else begin
                    r_dead <= 1'b1;
                end
            end
            default: begin
                r_node <= r_node;
            end
        endcase
    end

    // trie bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= CW'(1);
            r_nonempty   <= 1'b0;
            r_best       <= '0;
        end else begin
            unique case (w_ctl.act)
                A_ROOT: begin
                    r_nodes_used <= CW'(1);
                    r_nonempty   <= 1'b0;
                end
                A_CLEAR: begin
                    r_nodes_used <= CW'(1);
                    r_nonempty   <= 1'b0;
                    r_best       <= '0;
                end
                A_INS_STEP: begin
                    if (!w_hit) begin
                        r_nodes_used <= r_nodes_used + CW'(1);
                    end
                end
                A_INS_END: begin
                    r_nonempty <= 1'b1;
                end
                A_QRY_END: begin
                    if (w_acc32 > r_best) begin
                        r_best <= w_acc32;
                    end
                end
                default: begin
                    r_nonempty <= r_nonempty;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.act == A_EMIT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.act == A_EMIT && !w_out_busy) begin
            r_out_best  <= w_acc32;
            r_out_run   <= r_best;
            r_out_empty <= r_flag_empty;
            r_out_full  <= r_flag_full;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.best_xor     = r_out_best;
    assign o_rsp.running_best = r_out_run;
    assign o_rsp.set_empty    = r_out_empty;
    assign o_rsp.pool_full    = r_out_full;

    `BTMX_CHECK(a_pool_bound, r_nodes_used <= CW'(NODE_COUNT), "node allocator overran pool")
    `BTMX_IMPLY(a_write_alloc, w_we, {1'b0, w_waddr} < r_nodes_used, "write to unallocated node")
    `BTMX_NEXT(a_one_in_flight, w_accept, !i_req.ready, "second item taken while busy")
    `BTMX_IMPLY(a_run_covers, r_out_valid, r_out_run >= r_out_best, "running max below result")
    `BTMX_IMPLY(a_flag_zero, r_out_valid && (r_out_empty || r_out_full), r_out_best == '0, "flag with xor")
endmodule

// File: rtl/btmx_seq.sv
`timescale 1ns / 1ps
module btmx_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btmx_pkg::t_flags  i_flags,
    output btmx_pkg::t_uword  o_ctl
);
    import btmx_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_word;
    logic              w_taken;

    assign w_word = uc_fetch(r_step);
    assign o_ctl  = w_word;

    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:   w_taken = 1'b1;
            C_NO_ITEM:  w_taken = i_flags.no_item;
            C_CMD_INS:  w_taken = i_flags.cmd_ins;
            C_CMD_QRY:  w_taken = i_flags.cmd_qry;
            C_CMD_CLR:  w_taken = i_flags.cmd_clr;
            C_POOL_LOW: w_taken = i_flags.pool_low;
            C_MORE:     w_taken = i_flags.more;
            C_EMPTY:    w_taken = i_flags.empty;
            C_OUT_BUSY: w_taken = i_flags.out_busy;
            default:    w_taken = 1'b1;
        endcase
    end

    assign n_step = w_taken ? w_word.target : r_step + STEP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_RST;
        end else begin
            r_step <= n_step;
        end
    end
endmodule

// File: bench/binary_trie_max_xor_tb.sv
`timescale 1ns / 1ps
module binary_trie_max_xor_tb;
    import btmx_pkg::*;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 4096;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [VALUE_W-1:0] best_xor;
        logic [VALUE_W-1:0] running_best;
        logic               set_empty;
        logic               pool_full;
    } t_xor_result;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_THIRD, RX_SPARSE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    btmx_req_if req_if ();
    btmx_rsp_if rsp_if ();

    binary_trie_max_xor #(
        .KEY_BITS  (KEY_BITS),
        .NODE_COUNT(NODE_COUNT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // trie copy used for prediction
    int unsigned        trie_zero [NODE_COUNT];
    int unsigned        trie_one  [NODE_COUNT];
    int unsigned        pool_used;
    bit                 trie_holds_key;
    logic [VALUE_W-1:0] best_seen;

    t_xor_result        pending_results [$];
    logic [VALUE_W-1:0] stored_keys [$];

    int mismatch_count;
    int results_checked;
    int n_insert, n_rejected, n_query, n_empty_query, n_clear, n_nop;
    int burst_left;
    bit hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 25)
            $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task automatic empty_trie();
        trie_zero[0]   = 0;
        trie_one[0]    = 0;
        pool_used      = 1;
        trie_holds_key = 1'b0;
        stored_keys.delete();
    endtask

    task automatic predict_result(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        t_xor_result        r;
        int unsigned        node;
        int unsigned        nxt;
        int unsigned        opp;
        logic [VALUE_W-1:0] acc;
        r   = '0;
        acc = '0;
        case (cmd)
            CMD_INSERT: begin
                n_insert++;
                if (NODE_COUNT - pool_used < KEY_BITS) begin
                    r.pool_full = 1'b1;
                    n_rejected++;
                end else begin
                    node = 0;
                    for (int i = KEY_BITS - 1; i >= 0; i--) begin
                        nxt = val[i] ? trie_one[node] : trie_zero[node];
                        if (nxt == 0) begin
                            nxt = pool_used;
                            pool_used++;
                            trie_zero[nxt] = 0;
                            trie_one[nxt]  = 0;
                            if (val[i]) trie_one[node] = nxt;
                            else trie_zero[node] = nxt;
                        end
                        node = nxt;
                    end
                    trie_holds_key = 1'b1;
                    stored_keys.push_back(val);
                end
            end
            CMD_QUERY: begin
                n_query++;
                if (!trie_holds_key) begin
                    r.set_empty = 1'b1;
                    n_empty_query++;
                end else begin
                    node = 0;
                    for (int i = KEY_BITS - 1; i >= 0; i--) begin
                        opp = val[i] ? trie_zero[node] : trie_one[node];
                        if (opp != 0) begin
                            acc[i] = 1'b1;
                            node   = opp;
                        end else begin
                            nxt = val[i] ? trie_one[node] : trie_zero[node];
                            if (nxt == 0) break;
                            node = nxt;
                        end
                    end
                    if (acc > best_seen) best_seen = acc;
                    r.best_xor = acc;
                end
            end
            CMD_CLEAR: begin
                n_clear++;
                empty_trie();
                best_seen = '0;
            end
            default: n_nop++;
        endcase
        r.running_best = best_seen;
        pending_results.push_back(r);
    endtask

    // one beat on the request side, with bursts and gaps
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.value   <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_result(cmd, val);
        burst_left--;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 r;
        r = $urandom_range(0, 99);
        v = $urandom();
        if (stored_keys.size() > 0 && r < 20)
            v = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (stored_keys.size() > 0 && r < 35)
            v = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                ^ (32'd1 << $urandom_range(0, 31));
        else if (stored_keys.size() > 0 && r < 50)
            v = ~stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (r < 55)
            v = '0;
        else if (r < 60)
            v = '1;
        else if (r < 65)
            v = 32'd1 << $urandom_range(0, 31);
        return v;
    endfunction

    task automatic test_directed();
        send_item(CMD_QUERY,  32'h0000_0000);
        send_item(CMD_NOP,    32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'h0000_0000);
        send_item(CMD_QUERY,  32'h0000_0000);
        send_item(CMD_QUERY,  32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF);
        send_item(CMD_QUERY,  32'h0000_0000);
        send_item(CMD_QUERY,  32'h8000_0000);
        send_item(CMD_INSERT, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h5555_5555);
        send_item(CMD_QUERY,  32'hAAAA_AAAA);
        send_item(CMD_QUERY,  32'h0000_0001);
        send_item(CMD_NOP,    32'h0000_0000);
        send_item(CMD_CLEAR,  32'hFFFF_FFFF);
        send_item(CMD_QUERY,  32'h1234_5678);
        send_item(CMD_INSERT, 32'h0000_0001);
        send_item(CMD_QUERY,  32'h0000_0001);
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_QUERY,  32'h7FFF_FFFF);
        send_item(CMD_CLEAR,  32'h0000_0000);
    endtask

    // fill the node pool until inserts are refused
    task automatic test_pool_exhaustion();
        int tries;
        send_item(CMD_CLEAR, $urandom());
        tries = 0;
        while (NODE_COUNT - pool_used >= KEY_BITS && tries < 400) begin
            send_item(CMD_INSERT, $urandom());
            tries++;
        end
        send_item(CMD_INSERT, $urandom());
        send_item(CMD_INSERT, stored_keys[0]);
        send_item(CMD_INSERT, 32'h0000_0000);
        for (int i = 0; i < 6; i++) send_item(CMD_QUERY, pick_value());
        send_item(CMD_NOP, $urandom());
        send_item(CMD_CLEAR, $urandom());
        send_item(CMD_QUERY, $urandom());
        send_item(CMD_INSERT, $urandom());
        send_item(CMD_QUERY, $urandom());
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) send_item(CMD_INSERT, $urandom());
            else send_item(CMD_QUERY, pick_value());
        end
    endtask

    task automatic test_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 42) send_item(CMD_INSERT, pick_value());
            else if (r < 93) send_item(CMD_QUERY, pick_value());
            else if (r < 97) send_item(CMD_CLEAR, $urandom());
            else send_item(CMD_NOP, $urandom());
        end
    endtask

    // response side stall pattern and long hold-off
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:        rsp_if.ready <= 1'b1;
                    RX_RANDOM:      rsp_if.ready <= ($urandom_range(0, 99) >= 30);
                    RX_EVERY_THIRD: rsp_if.ready <= (phase % 3 == 0);
                    default:        rsp_if.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_xor_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", rsp_if.best_xor, '0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (rsp_if.best_xor !== want.best_xor)
                    report_mismatch("best_xor", rsp_if.best_xor, want.best_xor);
                if (rsp_if.running_best !== want.running_best)
                    report_mismatch("running_best", rsp_if.running_best, want.running_best);
                if (rsp_if.set_empty !== want.set_empty)
                    report_mismatch("set_empty", 32'(rsp_if.set_empty), 32'(want.set_empty));
                if (rsp_if.pool_full !== want.pool_full)
                    report_mismatch("pool_full", 32'(rsp_if.pool_full), 32'(want.pool_full));
            end
        end
    end

    initial begin
        int waited;
        mismatch_count  = 0;
        results_checked = 0;
        burst_left      = 0;
        hold_request    = 1'b0;
        best_seen       = '0;
        empty_trie();
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.command <= CMD_INSERT;
        req_if.value   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pool_exhaustion();
        test_backpressure();
        test_random(480);
        test_backpressure();
        test_random(60);

        req_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("missing beats", '0, 32'(pending_results.size()));

        $display("covered %0d inserts (%0d refused on a full pool), %0d queries (%0d on an empty set)",
                 n_insert, n_rejected, n_query, n_empty_query);
        $display("plus %0d clears and %0d unused commands; %0d result beats checked",
                 n_clear, n_nop, results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
